// ===== src/wtrs_pkg.sv =====
// wtrs_pkg: shared sizes, codes, types and bit helpers for the wavelet tree block
// no dependencies
package wtrs_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int VALUE_BITS   = 8;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int WRK_W        = CNT_W + 2;
    localparam int LVL_W        = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int CNT_AW       = LVL_W + IDX_W;
    localparam int WORK_AW      = IDX_W + 1;

    localparam logic [1:0] FUNC_LOAD  = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_SWAP  = 2'd2;

    localparam logic [1:0] STATUS_DONE   = 2'd0;
    localparam logic [1:0] STATUS_ABSENT = 2'd1;
    localparam logic [1:0] STATUS_RANGE  = 2'd2;

    typedef logic [VALUE_BITS-1:0]   value_t;
    typedef logic [CNT_W-1:0]        count_t;
    typedef logic signed [WRK_W-1:0] wrk_t;
    typedef logic [LVL_W-1:0]        level_t;

    // bit of a value that steers it at a given level, msb first
    function automatic logic bit_at(input value_t x, input level_t lvl);
        bit_at = x[VALUE_BITS - 1 - int'(lvl)];
    endfunction

    // the value bits already decided above a given level
    function automatic value_t prefix_mask(input level_t lvl);
        prefix_mask = ~({VALUE_BITS{1'b1}} >> lvl);
    endfunction

endpackage

// ===== src/wavelet_tree_rank_select.sv =====
// wavelet_tree_rank_select: top level, load, tree build, select, occurrence search, swap
// depends on wtrs_pkg and wtrs_ram
//
//  channel   direction  signals                                         role
//  s_        in         s_valid s_ready s_func s_element_value ...      item transaction
//  m_        out        m_valid m_ready m_found_position ...            result transaction
//  cfg_      in         cfg_valid cfg_ready cfg_data                    element_count write
//
//  one item at a time; a load writes one element, a swap walks the levels at most once,
//  a query walks them once to select, then once per count (one count over the whole sequence
//  plus log2 of the loaded count in the binary search); the last load triggers the build,
//  three passes per level over each node segment through the work ram's single read port
//  every level step takes four reads of the count ram, each data word registered by the ram
//  reset is synchronous active low and clears control only; both rams start undefined
//  a finished result waits in the output register; only a new finish waits on m_ready
module wavelet_tree_rank_select
    import wtrs_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [10:0]   cfg_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic [1:0]    s_func,
    input  logic [7:0]    s_element_value,
    input  logic [9:0]    s_query_position,
    input  logic [10:0]   s_rank,
    input  logic [10:0]   s_occurrence,
    input  logic [9:0]    s_swap_position,
    output logic          m_valid,
    input  logic          m_ready,
    output logic signed [10:0] m_found_position,
    output logic [7:0]    m_selected_value,
    output logic [1:0]    m_status
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_BA_RD, S_BA_DT, S_BB_RD, S_BB_DT,
        S_LV_RD, S_LV_CALC, S_WALK_END, S_BS_CHK, S_FIN
    } state_t;

    // what the level walk is doing for the current item
    typedef enum logic [1:0] {ST_SEL, ST_CALL, ST_CMID, ST_SWAP} stage_t;

    localparam wrk_t   WRK_MAX   = wrk_t'(MAX_ELEMENTS);
    localparam wrk_t   WRK_ONE   = wrk_t'(1);
    localparam wrk_t   WRK_NONE  = wrk_t'(-1);
    localparam count_t CNT_MAX   = count_t'(MAX_ELEMENTS);
    localparam count_t CNT_ONE   = count_t'(1);
    localparam level_t LVL_LAST  = level_t'(VALUE_BITS - 1);

    state_t state_reg;
    stage_t stage_reg;

    // configuration and sequence bookkeeping
    count_t ec_reg;
    count_t loaded_reg;
    logic   built_reg;

    // latched item
    logic [1:0] func_reg;
    value_t     val_reg;
    count_t     qpos_reg;
    count_t     rank_reg;
    count_t     occ_reg;
    count_t     swp_reg;

    // build sweep
    level_t bd_reg;
    count_t bs_reg;
    count_t bi_reg;
    count_t be_reg;
    count_t z_reg;
    count_t w_reg;
    value_t key_reg;
    logic   first_reg;
    logic   ones_reg;
    logic   bank_reg;

    // level walk
    level_t d_reg;
    logic [2:0] ph_reg;
    logic   vld_reg;
    count_t cap_reg [4];
    wrk_t   ws_reg, we_reg, wa_reg, wb_reg, wk_reg;
    value_t v_reg;
    value_t sel_reg;

    // binary search
    count_t lo_reg, hi_reg, mid_reg;

    // result
    count_t res_found_reg;
    value_t res_sel_reg;
    logic [1:0] res_status_reg;
    logic   m_valid_reg;
    count_t m_found_reg;
    value_t m_sel_reg;
    logic [1:0] m_status_reg;

    // ram ports
    logic                wk_we;
    logic [WORK_AW-1:0]  wk_waddr, wk_raddr;
    value_t              wk_wdata, wk_rdata;
    logic                cn_we;
    logic [CNT_AW-1:0]   cn_waddr, cn_raddr;
    count_t              cn_wdata, cn_rdata;

    wtrs_ram #(.AW(WORK_AW), .DW(VALUE_BITS)) u_work_ram (
        .aclk    (aclk),
        .wr_en   (wk_we),
        .wr_addr (wk_waddr),
        .wr_data (wk_wdata),
        .rd_addr (wk_raddr),
        .rd_data (wk_rdata)
    );

    wtrs_ram #(.AW(CNT_AW), .DW(CNT_W)) u_count_ram (
        .aclk    (aclk),
        .wr_en   (cn_we),
        .wr_addr (cn_waddr),
        .wr_data (cn_wdata),
        .rd_addr (cn_raddr),
        .rd_data (cn_rdata)
    );

    assign cfg_ready        = 1'b1;
    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_found_position = $signed(m_found_reg);
    assign m_selected_value = m_sel_reg;
    assign m_status         = m_status_reg;

    // load target, clamped to the legal element count
    count_t target;
    count_t loaded_inc;
    always_comb begin
        if (ec_reg == '0) begin
            target = CNT_ONE;
        end else if (ec_reg > CNT_MAX) begin
            target = CNT_MAX;
        end else begin
            target = ec_reg;
        end
        loaded_inc = loaded_reg + count_t'(loaded_reg < CNT_MAX);
    end

    // build segment tests on the element just read
    logic   b_bit;
    logic   b_match;
    count_t b_znew;
    always_comb begin
        b_bit   = bit_at(wk_rdata, bd_reg);
        b_match = first_reg || (((wk_rdata ^ key_reg) & prefix_mask(bd_reg)) == '0);
        b_znew  = z_reg + count_t'(!b_bit);
    end

    // level walk read slots, the node total always in the last slot
    wrk_t x_slot [4];
    wrk_t x_cur;
    logic x_ok;
    always_comb begin
        case (stage_reg)
            ST_SEL: begin
                x_slot[0] = wa_reg - WRK_ONE;
                x_slot[1] = wb_reg;
                x_slot[2] = WRK_NONE;
            end
            ST_SWAP: begin
                x_slot[0] = wa_reg - WRK_ONE;
                x_slot[1] = wa_reg;
                x_slot[2] = wa_reg + WRK_ONE;
            end
            default: begin
                x_slot[0] = (wa_reg > 0) ? ws_reg + wa_reg - WRK_ONE : WRK_NONE;
                x_slot[1] = WRK_NONE;
                x_slot[2] = WRK_NONE;
            end
        endcase
        x_slot[3] = we_reg - WRK_ONE;
        x_cur     = x_slot[ph_reg[1:0]];
        // counts before the node start, or off either end, read as zero
        x_ok      = (x_cur >= ws_reg) && (x_cur >= 0) && (x_cur < WRK_MAX);
    end

    // one level step of the walk
    wrk_t   c0, c1, c2, tot, cdiff, ns;
    wrk_t   n_ws, n_we, n_wa, n_wb, n_wk;
    value_t n_v;
    logic   fl, sl, stop, sw_wr;
    count_t sw_data;
    always_comb begin
        c0    = wrk_t'(cap_reg[0]);
        c1    = wrk_t'(cap_reg[1]);
        c2    = wrk_t'(cap_reg[2]);
        tot   = wrk_t'(cap_reg[3]);
        cdiff = c1 - c0;
        ns    = ws_reg + tot;
        n_ws  = ws_reg;
        n_we  = we_reg;
        n_wa  = wa_reg;
        n_wb  = wb_reg;
        n_wk  = wk_reg;
        n_v   = v_reg;
        fl    = (c1 - c0) == WRK_ONE;
        sl    = (c2 - c1) == WRK_ONE;
        stop  = 1'b0;
        sw_wr = 1'b0;
        sw_data = '0;
        case (stage_reg)
            ST_SEL: begin
                n_v = {v_reg[VALUE_BITS-2:0], 1'b0};
                if (wk_reg <= cdiff) begin
                    n_we = ns;
                    n_wa = ws_reg + c0;
                    n_wb = ws_reg + c1 - WRK_ONE;
                end else begin
                    n_ws = ns;
                    n_wa = ns + (wa_reg - ws_reg) - c0;
                    n_wb = ns + (wb_reg - ws_reg + WRK_ONE - c1) - WRK_ONE;
                    n_wk = wk_reg - cdiff;
                    n_v[0] = 1'b1;
                end
            end
            ST_SWAP: begin
                if (fl == sl) begin
                    if (fl) begin
                        n_we = ns;
                        n_wa = ws_reg + c1 - WRK_ONE;
                    end else begin
                        n_ws = ns;
                        n_wa = ns + (wa_reg - ws_reg + WRK_ONE - c1) - WRK_ONE;
                    end
                end else begin
                    // the pair parts here: only this count moves
                    stop    = 1'b1;
                    sw_wr   = 1'b1;
                    sw_data = fl ? cap_reg[1] - CNT_ONE : cap_reg[1] + CNT_ONE;
                end
            end
            default: begin
                if (!bit_at(sel_reg, d_reg)) begin
                    n_we = ns;
                    n_wa = c0;
                end else begin
                    n_ws = ns;
                    n_wa = wa_reg - c0;
                end
            end
        endcase
    end

    // ram port steering
    always_comb begin
        wk_we    = 1'b0;
        wk_waddr = {bank_reg, bi_reg[IDX_W-1:0]};
        wk_wdata = wk_rdata;
        wk_raddr = {bank_reg, bi_reg[IDX_W-1:0]};
        cn_we    = 1'b0;
        cn_waddr = {bd_reg, bi_reg[IDX_W-1:0]};
        cn_wdata = b_znew;
        cn_raddr = {d_reg, x_cur[IDX_W-1:0]};
        case (state_reg)
            S_DISP: begin
                wk_we    = (func_reg == FUNC_LOAD) && !built_reg && (loaded_reg < CNT_MAX);
                wk_waddr = {1'b0, loaded_reg[IDX_W-1:0]};
                wk_wdata = val_reg;
            end
            S_BA_DT: begin
                cn_we = b_match;
            end
            S_BB_DT: begin
                wk_we    = (b_bit == ones_reg);
                wk_waddr = {~bank_reg, w_reg[IDX_W-1:0]};
            end
            S_LV_CALC: begin
                cn_we    = sw_wr;
                cn_waddr = {d_reg, wa_reg[IDX_W-1:0]};
                cn_wdata = sw_data;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            stage_reg   <= ST_SEL;
            ec_reg      <= CNT_MAX;
            loaded_reg  <= '0;
            built_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            ph_reg      <= '0;
            bank_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                ec_reg <= cfg_data;
            end
            // the finish state refills the output register itself
            if (m_valid_reg && m_ready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        func_reg  <= s_func;
                        val_reg   <= s_element_value;
                        qpos_reg  <= {1'b0, s_query_position};
                        rank_reg  <= s_rank;
                        occ_reg   <= s_occurrence;
                        swp_reg   <= {1'b0, s_swap_position};
                        state_reg <= S_DISP;
                    end
                end

                S_DISP: begin
                    res_found_reg  <= '0;
                    res_sel_reg    <= '0;
                    res_status_reg <= STATUS_DONE;
                    state_reg      <= S_FIN;
                    ws_reg <= '0;
                    we_reg <= wrk_t'(loaded_reg);
                    d_reg  <= '0;
                    ph_reg <= '0;
                    case (func_reg)
                        FUNC_LOAD: begin
                            if (built_reg) begin
                                res_status_reg <= STATUS_RANGE;
                            end else begin
                                loaded_reg <= loaded_inc;
                                if (loaded_inc >= target) begin
                                    bd_reg    <= '0;
                                    bs_reg    <= '0;
                                    bi_reg    <= '0;
                                    z_reg     <= '0;
                                    first_reg <= 1'b1;
                                    bank_reg  <= 1'b0;
                                    state_reg <= S_BA_RD;
                                end
                            end
                        end
                        FUNC_QUERY: begin
                            if (!built_reg || qpos_reg >= loaded_reg || rank_reg == '0 ||
                                rank_reg > qpos_reg + CNT_ONE || occ_reg == '0) begin
                                res_found_reg  <= '1;
                                res_status_reg <= STATUS_RANGE;
                            end else begin
                                stage_reg <= ST_SEL;
                                wa_reg    <= '0;
                                wb_reg    <= wrk_t'(qpos_reg);
                                wk_reg    <= wrk_t'(rank_reg);
                                v_reg     <= '0;
                                state_reg <= S_LV_RD;
                            end
                        end
                        FUNC_SWAP: begin
                            if (!built_reg || swp_reg >= loaded_reg) begin
                                res_status_reg <= STATUS_RANGE;
                            end else if (swp_reg != loaded_reg - CNT_ONE) begin
                                stage_reg <= ST_SWAP;
                                wa_reg    <= wrk_t'(swp_reg);
                                state_reg <= S_LV_RD;
                            end
                        end
                        default: begin
                            res_status_reg <= STATUS_RANGE;
                        end
                    endcase
                end

                // build pass over one segment: counts of left-going elements
                S_BA_RD: begin
                    if (bi_reg == loaded_reg) begin
                        be_reg    <= bi_reg;
                        bi_reg    <= bs_reg;
                        w_reg     <= bs_reg;
                        ones_reg  <= 1'b0;
                        state_reg <= S_BB_RD;
                    end else begin
                        state_reg <= S_BA_DT;
                    end
                end

                S_BA_DT: begin
                    if (b_match) begin
                        if (first_reg) begin
                            key_reg <= wk_rdata;
                        end
                        first_reg <= 1'b0;
                        z_reg     <= b_znew;
                        bi_reg    <= bi_reg + CNT_ONE;
                        state_reg <= S_BA_RD;
                    end else begin
                        be_reg    <= bi_reg;
                        bi_reg    <= bs_reg;
                        w_reg     <= bs_reg;
                        ones_reg  <= 1'b0;
                        state_reg <= S_BB_RD;
                    end
                end

                // stable partition of the segment into the other bank, zeros then ones
                S_BB_RD: begin
                    if (bi_reg == be_reg) begin
                        if (!ones_reg) begin
                            ones_reg <= 1'b1;
                            bi_reg   <= bs_reg;
                        end else if (be_reg == loaded_reg) begin
                            bank_reg  <= ~bank_reg;
                            bd_reg    <= bd_reg + level_t'(1);
                            bs_reg    <= '0;
                            bi_reg    <= '0;
                            z_reg     <= '0;
                            first_reg <= 1'b1;
                            if (bd_reg == LVL_LAST) begin
                                built_reg <= 1'b1;
                                state_reg <= S_FIN;
                            end else begin
                                state_reg <= S_BA_RD;
                            end
                        end else begin
                            bs_reg    <= be_reg;
                            z_reg     <= '0;
                            first_reg <= 1'b1;
                            state_reg <= S_BA_RD;
                        end
                    end else begin
                        state_reg <= S_BB_DT;
                    end
                end

                S_BB_DT: begin
                    if (b_bit == ones_reg) begin
                        w_reg <= w_reg + CNT_ONE;
                    end
                    bi_reg    <= bi_reg + CNT_ONE;
                    state_reg <= S_BB_RD;
                end

                // four count reads per level, each data word in the cycle after its address
                S_LV_RD: begin
                    vld_reg <= x_ok;
                    if (ph_reg != 3'd0) begin
                        cap_reg[2'(ph_reg - 3'd1)] <= vld_reg ? cn_rdata : '0;
                    end
                    if (ph_reg == 3'd4) begin
                        ph_reg    <= '0;
                        state_reg <= S_LV_CALC;
                    end else begin
                        ph_reg <= ph_reg + 3'd1;
                    end
                end

                S_LV_CALC: begin
                    ws_reg <= n_ws;
                    we_reg <= n_we;
                    wa_reg <= n_wa;
                    wb_reg <= n_wb;
                    wk_reg <= n_wk;
                    v_reg  <= n_v;
                    if (stop || d_reg == LVL_LAST) begin
                        state_reg <= S_WALK_END;
                    end else begin
                        d_reg     <= d_reg + level_t'(1);
                        state_reg <= S_LV_RD;
                    end
                end

                S_WALK_END: begin
                    ws_reg <= '0;
                    we_reg <= wrk_t'(loaded_reg);
                    d_reg  <= '0;
                    case (stage_reg)
                        ST_SEL: begin
                            // count the selected value over the whole sequence
                            sel_reg   <= v_reg;
                            wa_reg    <= wrk_t'(loaded_reg);
                            stage_reg <= ST_CALL;
                            state_reg <= S_LV_RD;
                        end
                        ST_CALL: begin
                            if (wa_reg < wrk_t'(occ_reg)) begin
                                res_found_reg  <= '1;
                                res_sel_reg    <= sel_reg;
                                res_status_reg <= STATUS_ABSENT;
                                state_reg      <= S_FIN;
                            end else begin
                                lo_reg    <= '0;
                                hi_reg    <= loaded_reg - CNT_ONE;
                                state_reg <= S_BS_CHK;
                            end
                        end
                        ST_CMID: begin
                            if (wa_reg >= wrk_t'(occ_reg)) begin
                                hi_reg <= mid_reg;
                            end else begin
                                lo_reg <= mid_reg + CNT_ONE;
                            end
                            state_reg <= S_BS_CHK;
                        end
                        default: begin
                            state_reg <= S_FIN;
                        end
                    endcase
                end

                // first position whose prefix holds occurrence copies of the value
                S_BS_CHK: begin
                    if (lo_reg < hi_reg) begin
                        mid_reg   <= CNT_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
                        wa_reg    <= wrk_t'(CNT_W'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1))
                                     + WRK_ONE;
                        stage_reg <= ST_CMID;
                        state_reg <= S_LV_RD;
                    end else begin
                        res_found_reg  <= lo_reg;
                        res_sel_reg    <= sel_reg;
                        res_status_reg <= STATUS_DONE;
                        state_reg      <= S_FIN;
                    end
                end

                S_FIN: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_found_reg  <= res_found_reg;
                        m_sel_reg    <= res_sel_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // an accepted transaction always moves to dispatch
    a_accept_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_DISP))
        else $error("accepted item not dispatched");

    // the tree once built stays built and the sequence length is frozen
    a_built_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        built_reg |=> (built_reg && $stable(loaded_reg)))
        else $error("built tree disturbed");

    // counts only change while building or repairing after a swap
    a_count_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cn_we |-> (state_reg == S_BA_DT || (state_reg == S_LV_CALC && stage_reg == ST_SWAP)))
        else $error("count ram written outside build or swap");

    // the walk never reads past the fourth slot
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LV_RD) |-> (ph_reg <= 3'd4))
        else $error("level read phase out of range");

endmodule

// ===== src/wtrs_ram.sv =====
// wtrs_ram: simple dual port synchronous ram, one write and one registered read
// no dependencies
module wtrs_ram #(
    parameter int AW = 10,
    parameter int DW = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
